@@ rtl/core/rre_pkg.sv @@
package rre_pkg;

    // Field widths of the channels
    localparam int ELEM_W  = 32;
    localparam int POS_W   = 12;
    localparam int COUNT_W = 13;
    localparam int MODE_W  = 2;

    // Parameter defaults
    localparam int MAX_RUN_LENGTH_DEF = 4096;
    localparam int DATA_WIDTH_DEF     = 32;
    localparam int IDX_W_DEF          = $clog2(MAX_RUN_LENGTH_DEF);
    localparam int CNT_W_DEF          = $clog2(MAX_RUN_LENGTH_DEF + 1);
    localparam int ACC_W_DEF          = DATA_WIDTH_DEF + IDX_W_DEF + 1;

    // Reduction modes
    localparam logic [MODE_W-1:0] MODE_SUM  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MEAN = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MAX  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_MIN  = 2'd3;

    typedef struct packed {
        logic signed [ELEM_W-1:0] element;
        logic                     last;
    } in_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] reduced;
        logic [POS_W-1:0]         position;
        logic [COUNT_W-1:0]       count;
        logic                     saturated;
    } out_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic div_start;
        logic emit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic mode_mean;
        logic div_done;
    } sts_t;

endpackage

@@ rtl/core/rre_div.sv @@
module rre_div #(
    parameter int NUM_W = rre_pkg::ACC_W_DEF,
    parameter int DEN_W = rre_pkg::CNT_W_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic [NUM_W-1:0] quot,
    output logic             done
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DEN_W:0]    rem_reg, rem_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [DEN_W-1:0]  den_reg, den_next;

    logic [DEN_W:0]    shifted;
    logic [DEN_W+1:0]  trial;

    // Shift one numerator bit into the remainder and try the subtract
    assign shifted = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            step_next = STEP_W'(NUM_W);
            rem_next  = '0;
            quo_next  = numer;
            den_next  = denom;
        end
        else if (busy_reg)
        begin
            if (!trial[DEN_W+1])
            begin
                rem_next = trial[DEN_W:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Advance the operand registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign quot = quo_reg;
    assign done = done_reg;

    a_start_clears_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (busy_reg && !done_reg))
        else $error("divider did not restart cleanly");

    a_busy_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && done_reg))
        else $error("divider busy and done together");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ($fell(busy_reg) && !$past(start)) |-> done_reg)
        else $error("divider stopped without finishing");

endmodule

@@ rtl/core/rre_ctrl.sv @@
module rre_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          elem_valid,
    input  logic          elem_last,
    output logic          elem_ready,
    output logic          res_valid,
    input  logic          res_ready,
    input  rre_pkg::sts_t sts,
    output rre_pkg::cmd_t cmd
);

    localparam logic [1:0] S_RUN  = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       res_valid_reg, res_valid_next;
    logic       accept;

    // Take elements while the result register is free or draining
    assign elem_ready = (state_reg == S_RUN) && (!res_valid_reg || res_ready);
    assign accept     = elem_valid && elem_ready;

    always_comb
    begin
        state_next    = state_reg;
        cmd.accept    = 1'b0;
        cmd.div_start = 1'b0;
        cmd.emit      = 1'b0;
        unique case (state_reg)
            S_RUN:
            begin
                cmd.accept = accept;
                if (accept && elem_last)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (sts.mode_mean)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_RUN;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = S_RUN;
            end
        endcase
    end

    // Set on emit, drop when the transaction completes
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;

    a_last_leaves_run: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && elem_last) |=> (state_reg == S_LOAD))
        else $error("last element did not start the finish sequence");

    a_emit_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !res_valid_reg)
        else $error("result overwritten before it was taken");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_start || cmd.emit) |-> !accept)
        else $error("element taken while finishing a run");

endmodule

@@ rtl/core/rre_dp.sv @@
module rre_dp #(
    parameter int MAX_RUN_LENGTH = rre_pkg::MAX_RUN_LENGTH_DEF,
    parameter int DATA_WIDTH     = rre_pkg::DATA_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        mode_we,
    input  logic [rre_pkg::MODE_W-1:0]  mode_wdata,
    input  rre_pkg::in_t                elem_data,
    output rre_pkg::out_t               res_payload,
    input  rre_pkg::cmd_t               cmd,
    output rre_pkg::sts_t               sts
);

    localparam int IDX_W  = $clog2(MAX_RUN_LENGTH);
    localparam int CNT_W  = $clog2(MAX_RUN_LENGTH + 1);
    localparam int ACC_W  = DATA_WIDTH + IDX_W + 1;
    localparam int WIDE_W = 32;

    localparam logic [CNT_W-1:0]      MAX_CNT = CNT_W'(MAX_RUN_LENGTH);
    localparam logic [DATA_WIDTH-1:0] MAX_DW  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MIN_DW  = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic [rre_pkg::MODE_W-1:0] mode_reg;
    logic signed [ACC_W-1:0]      acc_reg, acc_next;
    logic signed [DATA_WIDTH-1:0] ext_reg, ext_next;
    logic [IDX_W-1:0]             idx_reg, idx_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic                         ovr_reg, ovr_next;
    rre_pkg::out_t                res_reg, res_next;

    logic signed [DATA_WIDTH-1:0] x_dw;
    logic signed [ACC_W-1:0]      x_acc;
    logic                         x_better;

    logic [ACC_W-DATA_WIDTH:0]    acc_top;
    logic                         sum_fits;
    logic [DATA_WIDTH-1:0]        sum_clip;
    logic [ACC_W-1:0]             acc_mag;
    logic [ACC_W-1:0]             quot;
    logic                         div_done;
    logic [DATA_WIDTH-1:0]        q_lo;
    logic [DATA_WIDTH-1:0]        mean_dw;

    logic signed [DATA_WIDTH-1:0] res_dw;
    logic [IDX_W-1:0]             pos_sel;
    logic                         sat_sel;
    logic [WIDE_W-1:0]            pos_wide;
    logic [WIDE_W-1:0]            cnt_wide;

    // Mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= rre_pkg::MODE_SUM;
        end
        else if (mode_we)
        begin
            mode_reg <= mode_wdata;
        end
    end

    // Sign-extend the incoming element
    assign x_dw  = elem_data.element[DATA_WIDTH-1:0];
    assign x_acc = ACC_W'(x_dw);
    assign x_better = (mode_reg == rre_pkg::MODE_MIN) ? (x_dw < ext_reg) : (x_dw > ext_reg);

    // Accumulate, track the first extreme, count, flag elements past the run limit; clear after emit
    always_comb
    begin
        acc_next = acc_reg;
        ext_next = ext_reg;
        idx_next = idx_reg;
        cnt_next = cnt_reg;
        ovr_next = ovr_reg;
        if (cmd.emit)
        begin
            acc_next = '0;
            ext_next = '0;
            idx_next = '0;
            cnt_next = '0;
            ovr_next = 1'b0;
        end
        else if (cmd.accept)
        begin
            if (cnt_reg >= MAX_CNT)
            begin
                ovr_next = 1'b1;
            end
            else
            begin
                acc_next = acc_reg + x_acc;
                if (cnt_reg == '0)
                begin
                    ext_next = x_dw;
                    idx_next = '0;
                end
                else if (x_better)
                begin
                    ext_next = x_dw;
                    idx_next = cnt_reg[IDX_W-1:0];
                end
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            ext_reg <= '0;
            idx_reg <= '0;
            cnt_reg <= '0;
            ovr_reg <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
            ext_reg <= ext_next;
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
            ovr_reg <= ovr_next;
        end
    end

    // Clip the sum to the data range
    assign acc_top  = acc_reg[ACC_W-1:DATA_WIDTH-1];
    assign sum_fits = (&acc_top) | ~(|acc_top);
    assign sum_clip = sum_fits ? acc_reg[DATA_WIDTH-1:0]
                               : (acc_reg[ACC_W-1] ? MIN_DW : MAX_DW);

    // Divide the magnitude of the sum by the count
    assign acc_mag = acc_reg[ACC_W-1] ? (~acc_reg + 1'b1) : acc_reg;

    rre_div #(
        .NUM_W (ACC_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .numer (acc_mag),
        .denom (cnt_reg),
        .quot  (quot),
        .done  (div_done)
    );

    // Restore the sign of the mean
    assign q_lo    = quot[DATA_WIDTH-1:0];
    assign mean_dw = acc_reg[ACC_W-1] ? (~q_lo + 1'b1) : q_lo;

    // Select the result by mode
    always_comb
    begin
        res_dw  = ext_reg;
        pos_sel = '0;
        sat_sel = ovr_reg;
        unique case (mode_reg)
            rre_pkg::MODE_SUM:
            begin
                res_dw  = sum_clip;
                sat_sel = ovr_reg | ~sum_fits;
            end
            rre_pkg::MODE_MEAN:
            begin
                res_dw = mean_dw;
            end
            rre_pkg::MODE_MAX, rre_pkg::MODE_MIN:
            begin
                res_dw  = ext_reg;
                pos_sel = idx_reg;
            end
        endcase
    end

    assign pos_wide = WIDE_W'(pos_sel);
    assign cnt_wide = WIDE_W'(cnt_reg);

    always_comb
    begin
        res_next = res_reg;
        if (cmd.emit)
        begin
            res_next.reduced   = rre_pkg::ELEM_W'(res_dw);
            res_next.position  = pos_wide[rre_pkg::POS_W-1:0];
            res_next.count     = cnt_wide[rre_pkg::COUNT_W-1:0];
            res_next.saturated = sat_sel;
        end
    end

    // Hold the result until the next emit
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_payload   = res_reg;
    assign sts.mode_mean = (mode_reg == rre_pkg::MODE_MEAN);
    assign sts.div_done  = div_done;

endmodule

@@ rtl/core/run_reduction_engine_core.sv @@
// Channel   Direction  Handshake                  Payload
// elem      in         elem_valid / elem_ready    elem_data   (rre_pkg::in_t)
// res       out        res_valid  / res_ready     res_payload (rre_pkg::out_t)
// mode      in         mode_we (no wait)          mode_wdata  (2 bits)
//
// Runs stream at one element per cycle while in the run state and the result register is free or draining.
// For sum, maximum and minimum the load state emits the result after the last element.
// For mean a restoring divider retires one quotient bit per cycle over DATA_WIDTH +
// clog2(MAX_RUN_LENGTH) + 1 bits, then the emit state sends the result.
// Reset clears the mode to sum and empties the run state; no clearing pass follows.
// A waiting result stalls the input until res_ready; both transactions can share that cycle.
module run_reduction_engine_core #(
    parameter int MAX_RUN_LENGTH = rre_pkg::MAX_RUN_LENGTH_DEF,
    parameter int DATA_WIDTH     = rre_pkg::DATA_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        elem_valid,
    output logic                        elem_ready,
    input  rre_pkg::in_t                elem_data,
    output logic                        res_valid,
    input  logic                        res_ready,
    output rre_pkg::out_t               res_payload,
    input  logic                        mode_we,
    input  logic [rre_pkg::MODE_W-1:0]  mode_wdata
);

    rre_pkg::cmd_t cmd;
    rre_pkg::sts_t sts;

    // Sequence accept, divide and emit
    rre_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .elem_valid (elem_valid),
        .elem_last  (elem_data.last),
        .elem_ready (elem_ready),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    // Accumulate runs and build results
    rre_dp #(
        .MAX_RUN_LENGTH (MAX_RUN_LENGTH),
        .DATA_WIDTH     (DATA_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .mode_we     (mode_we),
        .mode_wdata  (mode_wdata),
        .elem_data   (elem_data),
        .res_payload (res_payload),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule
